>>> hw/rtl/cbq_pkg.sv
// Shared types, constants and the per-segment micro-program for the cubic-to-quad block.
`default_nettype none
package cbq_pkg;

    localparam int MAX_QUADS = 64;
    localparam int COORD_W   = 24;
    localparam int GUARD     = 8;
    localparam int CFG_W     = 32;
    localparam int DW        = 36;
    localparam int XW        = 52;
    localparam int TW        = 27;
    localparam int AW        = 79;
    localparam int DNW       = 23;
    localparam int NW        = 7;
    localparam int IW        = 6;
    localparam int TVW       = 17;
    localparam int T_FRAC    = 16;
    localparam int EW        = 54;
    localparam int DXW       = 27;
    localparam int N3W       = 19;
    localparam int PCW       = 5;
    localparam int PROG_LEN  = 24;
    localparam int LW        = 4;
    localparam int RAM_DEPTH = 32;
    localparam int RAW       = 5;
    localparam int CNTW      = 5;

    localparam logic [CFG_W-1:0] TOL_RESET = 32'd1106;

    localparam logic signed [DW-1:0] COORD_MAX = DW'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [DW-1:0] COORD_MIN = -COORD_MAX - DW'(1);
    localparam logic signed [DW-1:0] GUARD_HALF = DW'(1 << (GUARD - 1));

    typedef logic [2:0] alu_mode_t;
    localparam alu_mode_t ALU_MUL  = 3'd0;
    localparam alu_mode_t ALU_DIV  = 3'd1;
    localparam alu_mode_t ALU_LERP = 3'd2;
    localparam alu_mode_t ALU_CTRL = 3'd3;
    localparam alu_mode_t ALU_SUB  = 3'd4;
    localparam alu_mode_t ALU_ADD  = 3'd5;

    typedef struct packed {
        logic                  start;
        alu_mode_t             mode;
        logic signed [XW-1:0]  a;
        logic signed [XW-1:0]  b;
        logic [TW-1:0]         t;
    } alu_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [AW-1:0]  result;
    } alu_rsp_t;

    typedef struct packed {
        alu_mode_t      op;
        logic [LW-1:0]  src_a;
        logic [LW-1:0]  src_b;
        logic [LW-1:0]  dst;
        logic           use_t1;
    } uop_t;

    // scratch slots, one bank per axis
    localparam logic [LW-1:0] L_P0 = 4'd0;
    localparam logic [LW-1:0] L_P1 = 4'd1;
    localparam logic [LW-1:0] L_P2 = 4'd2;
    localparam logic [LW-1:0] L_P3 = 4'd3;
    localparam logic [LW-1:0] L_D0 = 4'd4;
    localparam logic [LW-1:0] L_D1 = 4'd5;
    localparam logic [LW-1:0] L_D2 = 4'd6;
    localparam logic [LW-1:0] L_A  = 4'd7;
    localparam logic [LW-1:0] L_B  = 4'd8;
    localparam logic [LW-1:0] L_C  = 4'd9;
    localparam logic [LW-1:0] L_AB = 4'd10;
    localparam logic [LW-1:0] L_BC = 4'd11;
    localparam logic [LW-1:0] L_S  = 4'd12;
    localparam logic [LW-1:0] L_E  = 4'd13;
    localparam logic [LW-1:0] L_G  = 4'd14;
    localparam logic [LW-1:0] L_H  = 4'd15;

    function automatic uop_t prog_rom(input logic [PCW-1:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = uop_t'{ALU_SUB,  L_P1, L_P0, L_D0, 1'b0};
            5'd1:  u = uop_t'{ALU_SUB,  L_P2, L_P1, L_D1, 1'b0};
            5'd2:  u = uop_t'{ALU_SUB,  L_P3, L_P2, L_D2, 1'b0};
            5'd3:  u = uop_t'{ALU_LERP, L_P0, L_P1, L_A,  1'b0};
            5'd4:  u = uop_t'{ALU_LERP, L_P1, L_P2, L_B,  1'b0};
            5'd5:  u = uop_t'{ALU_LERP, L_P2, L_P3, L_C,  1'b0};
            5'd6:  u = uop_t'{ALU_LERP, L_A,  L_B,  L_AB, 1'b0};
            5'd7:  u = uop_t'{ALU_LERP, L_B,  L_C,  L_BC, 1'b0};
            5'd8:  u = uop_t'{ALU_LERP, L_AB, L_BC, L_S,  1'b0};
            5'd9:  u = uop_t'{ALU_LERP, L_D0, L_D1, L_A,  1'b0};
            5'd10: u = uop_t'{ALU_LERP, L_D1, L_D2, L_B,  1'b0};
            5'd11: u = uop_t'{ALU_LERP, L_A,  L_B,  L_G,  1'b0};
            5'd12: u = uop_t'{ALU_LERP, L_P0, L_P1, L_A,  1'b1};
            5'd13: u = uop_t'{ALU_LERP, L_P1, L_P2, L_B,  1'b1};
            5'd14: u = uop_t'{ALU_LERP, L_P2, L_P3, L_C,  1'b1};
            5'd15: u = uop_t'{ALU_LERP, L_A,  L_B,  L_AB, 1'b1};
            5'd16: u = uop_t'{ALU_LERP, L_B,  L_C,  L_BC, 1'b1};
            5'd17: u = uop_t'{ALU_LERP, L_AB, L_BC, L_E,  1'b1};
            5'd18: u = uop_t'{ALU_LERP, L_D0, L_D1, L_A,  1'b1};
            5'd19: u = uop_t'{ALU_LERP, L_D1, L_D2, L_B,  1'b1};
            5'd20: u = uop_t'{ALU_LERP, L_A,  L_B,  L_H,  1'b1};
            5'd21: u = uop_t'{ALU_SUB,  L_G,  L_H,  L_G,  1'b0};
            5'd22: u = uop_t'{ALU_ADD,  L_S,  L_E,  L_BC, 1'b0};
            5'd23: u = uop_t'{ALU_CTRL, L_BC, L_G,  L_H,  1'b0};
            default: u = uop_t'{ALU_SUB, L_P0, L_P0, L_A, 1'b0};
        endcase
        return u;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] c;
        c = v;
        if (v > COORD_MAX) begin
            c = COORD_MAX;
        end else if (v < COORD_MIN) begin
            c = COORD_MIN;
        end
        return COORD_W'(c);
    endfunction

    function automatic logic signed [DW-1:0] round_guard(input logic signed [DW-1:0] v);
        return (v + GUARD_HALF) >>> GUARD;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cubic_bezier_to_quads_top.sv
// Cubic Bezier to quadratic Bezier approximation: sequencer, scratch RAM and shared ALU.
// Input channel (s_*): one cubic per transaction, four Q15.8 points.
// Output channel (m_*): one quadratic per transaction, in order, with its index,
// a last flag and a flag that the segment count hit its cap.
// Configuration: cfg_wr_en/cfg_wr_data write the 32-bit tolerance; write while idle.
// s_ready is high only while the sequencer is idle; a cubic is then worked on alone.
// Work, all on the one serial ALU (one multiplier bit or one quotient bit per cycle):
//   load: the eight coordinates into the scratch RAM; error: two squares of up to 26 bits;
//   count search: per candidate n, four multiplies (n^2, n^3, tol*n^3, *n^3), n = 1..64;
//   per segment: a restoring divide for t, then 48 micro-ops (24 per axis), each
//   read from the scratch RAM and run on the ALU with t or 3*dt as multiplier.
// The output register holds a finished quadratic while the next one is computed;
// if m_ready stays low the sequencer waits with its next result in staging.
// Reset (aresetn, synchronous, active low) returns to idle, empties the output
// register and sets the tolerance to 1106. The scratch RAM needs no clearing.
`default_nettype none
module cubic_bezier_to_quads_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic        [cbq_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_start_x,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_start_y,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_ctrl1_x,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_ctrl1_y,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_ctrl2_x,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_ctrl2_y,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_end_x,
    input  wire logic signed [cbq_pkg::COORD_W-1:0]   s_end_y,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [cbq_pkg::COORD_W-1:0]   m_quad_start_x,
    output logic signed      [cbq_pkg::COORD_W-1:0]   m_quad_start_y,
    output logic signed      [cbq_pkg::COORD_W-1:0]   m_quad_ctrl_x,
    output logic signed      [cbq_pkg::COORD_W-1:0]   m_quad_ctrl_y,
    output logic signed      [cbq_pkg::COORD_W-1:0]   m_quad_end_x,
    output logic signed      [cbq_pkg::COORD_W-1:0]   m_quad_end_y,
    output logic             [cbq_pkg::IW-1:0]        m_segment_index,
    output logic                                      m_last_segment,
    output logic                                      m_count_capped
);
    import cbq_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LOAD  = 5'd1;
    localparam logic [4:0] ST_SQX   = 5'd2;
    localparam logic [4:0] ST_SQX_W = 5'd3;
    localparam logic [4:0] ST_SQY   = 5'd4;
    localparam logic [4:0] ST_SQY_W = 5'd5;
    localparam logic [4:0] ST_N2    = 5'd6;
    localparam logic [4:0] ST_N2_W  = 5'd7;
    localparam logic [4:0] ST_N3    = 5'd8;
    localparam logic [4:0] ST_N3_W  = 5'd9;
    localparam logic [4:0] ST_P1    = 5'd10;
    localparam logic [4:0] ST_P1_W  = 5'd11;
    localparam logic [4:0] ST_P2    = 5'd12;
    localparam logic [4:0] ST_P2_W  = 5'd13;
    localparam logic [4:0] ST_DIV   = 5'd14;
    localparam logic [4:0] ST_DIV_W = 5'd15;
    localparam logic [4:0] ST_RD    = 5'd16;
    localparam logic [4:0] ST_EXE   = 5'd17;
    localparam logic [4:0] ST_EXE_W = 5'd18;
    localparam logic [4:0] ST_OUT   = 5'd19;

    logic [4:0]                 state_reg, state_next;
    logic [CFG_W-1:0]           tol_reg;
    logic signed [COORD_W-1:0]  held_reg [8];
    logic [2:0]                 ld_reg;
    logic [EW-1:0]              err_reg;
    logic [NW-1:0]              n_reg;
    logic [N3W-1:0]             n3_reg;
    logic [XW-1:0]              p_reg;
    logic                       capped_reg;
    logic [IW-1:0]              i_reg;
    logic [TVW-1:0]             t0_reg;
    logic [TVW-1:0]             t1_reg;
    logic [PCW-1:0]             pc_reg;
    logic                       axis_reg;
    logic signed [COORD_W-1:0]  st_s_reg [2];
    logic signed [COORD_W-1:0]  st_c_reg [2];
    logic signed [COORD_W-1:0]  st_e_reg [2];
    logic                       m_valid_reg;

    uop_t                       uop;
    alu_req_t                   alu_req;
    alu_rsp_t                   alu_rsp;
    logic signed [DXW-1:0]      dx_x, dx_y;
    logic [DXW-1:0]             ax_x, ax_y;
    logic [EW-1:0]              e_w;
    logic [NW-1:0]              i_p1;
    logic [DNW-1:0]             div_num;
    logic [TVW-1:0]             dt;
    logic [TW-1:0]              dt3;
    logic                       out_free;
    logic                       last_seg;
    logic                       last_uop;
    logic                       found;
    logic                       ram_we;
    logic [RAW-1:0]             ram_waddr;
    logic [DW-1:0]              ram_wdata;
    logic [DW-1:0]              rd0, rd1;
    logic signed [DW-1:0]       res_d;

    always_comb begin
        uop  = prog_rom(pc_reg);
        dx_x = (DXW'(held_reg[4]) <<< 1) + DXW'(held_reg[4]) - DXW'(held_reg[6])
             - (DXW'(held_reg[2]) <<< 1) - DXW'(held_reg[2]) + DXW'(held_reg[0]);
        dx_y = (DXW'(held_reg[5]) <<< 1) + DXW'(held_reg[5]) - DXW'(held_reg[7])
             - (DXW'(held_reg[3]) <<< 1) - DXW'(held_reg[3]) + DXW'(held_reg[1]);
        ax_x = dx_x[DXW-1] ? DXW'(-dx_x) : DXW'(dx_x);
        ax_y = dx_y[DXW-1] ? DXW'(-dx_y) : DXW'(dx_y);
        e_w  = (err_reg + EW'((1 << GUARD) - 1)) >> GUARD;
        i_p1 = NW'(i_reg) + NW'(1);
        div_num = DNW'({i_p1, {T_FRAC{1'b0}}}) + DNW'(n_reg >> 1);
        dt   = t1_reg - t0_reg;
        dt3  = (TW'(dt) << 1) + TW'(dt);
        out_free = !m_valid_reg || m_ready;
        last_seg = i_p1 == n_reg;
        last_uop = pc_reg == PCW'(PROG_LEN - 1);
        found    = $unsigned(alu_rsp.result) >= AW'(e_w);
        res_d    = alu_rsp.result[DW-1:0];
    end

    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            ST_SQX: begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_MUL;
                alu_req.a     = XW'(ax_x);
                alu_req.t     = TW'(ax_x);
            end
            ST_SQY: begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_MUL;
                alu_req.a     = XW'(ax_y);
                alu_req.t     = TW'(ax_y);
            end
            ST_N2: begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_MUL;
                alu_req.a     = XW'(n_reg);
                alu_req.t     = TW'(n_reg);
            end
            ST_N3: begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_MUL;
                alu_req.a     = XW'(n3_reg);
                alu_req.t     = TW'(n_reg);
            end
            ST_P1: begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_MUL;
                alu_req.a     = XW'(tol_reg);
                alu_req.t     = TW'(n3_reg);
            end
            ST_P2: begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_MUL;
                alu_req.a     = $signed(p_reg);
                alu_req.t     = TW'(n3_reg);
            end
            ST_DIV: begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_DIV;
                alu_req.a     = XW'(div_num);
                alu_req.t     = TW'(n_reg);
            end
            ST_EXE: begin
                alu_req.start = 1'b1;
                alu_req.mode  = uop.op;
                alu_req.a     = XW'($signed(rd0));
                alu_req.b     = XW'($signed(rd1));
                if (uop.op == ALU_CTRL) begin
                    alu_req.t = dt3;
                end else begin
                    alu_req.t = TW'(uop.use_t1 ? t1_reg : t0_reg);
                end
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {ld_reg[0], 2'b00, ld_reg[2:1]};
        ram_wdata = DW'(held_reg[ld_reg]) <<< GUARD;
        if (state_reg == ST_LOAD) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_EXE_W && alu_rsp.done) begin
            ram_we    = 1'b1;
            ram_waddr = {axis_reg, uop.dst};
            ram_wdata = alu_rsp.result[DW-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_LOAD;
            ST_LOAD:  if (ld_reg == 3'd7) state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQX_W;
            ST_SQX_W: if (alu_rsp.done) state_next = ST_SQY;
            ST_SQY:   state_next = ST_SQY_W;
            ST_SQY_W: if (alu_rsp.done) state_next = ST_N2;
            ST_N2:    state_next = ST_N2_W;
            ST_N2_W:  if (alu_rsp.done) state_next = ST_N3;
            ST_N3:    state_next = ST_N3_W;
            ST_N3_W:  if (alu_rsp.done) state_next = ST_P1;
            ST_P1:    state_next = ST_P1_W;
            ST_P1_W:  if (alu_rsp.done) state_next = ST_P2;
            ST_P2:    state_next = ST_P2_W;
            ST_P2_W: begin
                if (alu_rsp.done) begin
                    if (found || n_reg == NW'(MAX_QUADS)) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_N2;
                    end
                end
            end
            ST_DIV:   state_next = ST_DIV_W;
            ST_DIV_W: if (alu_rsp.done) state_next = ST_RD;
            ST_RD:    state_next = ST_EXE;
            ST_EXE:   state_next = ST_EXE_W;
            ST_EXE_W: begin
                if (alu_rsp.done) begin
                    state_next = (last_uop && axis_reg) ? ST_OUT : ST_RD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = last_seg ? ST_IDLE : ST_DIV;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tol_reg     <= TOL_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        held_reg[0] <= s_start_x;
                        held_reg[1] <= s_start_y;
                        held_reg[2] <= s_ctrl1_x;
                        held_reg[3] <= s_ctrl1_y;
                        held_reg[4] <= s_ctrl2_x;
                        held_reg[5] <= s_ctrl2_y;
                        held_reg[6] <= s_end_x;
                        held_reg[7] <= s_end_y;
                        ld_reg      <= '0;
                        n_reg       <= NW'(1);
                    end
                end
                ST_LOAD:  ld_reg <= ld_reg + 3'd1;
                ST_SQX_W: if (alu_rsp.done) err_reg <= alu_rsp.result[EW-1:0];
                ST_SQY_W: if (alu_rsp.done) err_reg <= err_reg + alu_rsp.result[EW-1:0];
                ST_N2_W:  if (alu_rsp.done) n3_reg <= alu_rsp.result[N3W-1:0];
                ST_N3_W:  if (alu_rsp.done) n3_reg <= alu_rsp.result[N3W-1:0];
                ST_P1_W:  if (alu_rsp.done) p_reg <= alu_rsp.result[XW-1:0];
                ST_P2_W: begin
                    if (alu_rsp.done) begin
                        if (found || n_reg == NW'(MAX_QUADS)) begin
                            capped_reg <= !found;
                            i_reg      <= '0;
                            t0_reg     <= '0;
                        end else begin
                            n_reg <= n_reg + NW'(1);
                        end
                    end
                end
                ST_DIV_W: begin
                    if (alu_rsp.done) begin
                        t1_reg   <= alu_rsp.result[TVW-1:0];
                        pc_reg   <= '0;
                        axis_reg <= 1'b0;
                    end
                end
                ST_EXE_W: begin
                    if (alu_rsp.done) begin
                        if (uop.op == ALU_LERP && uop.dst == L_S) begin
                            st_s_reg[axis_reg] <= sat_coord(round_guard(res_d));
                        end
                        if (uop.op == ALU_LERP && uop.dst == L_E) begin
                            st_e_reg[axis_reg] <= sat_coord(round_guard(res_d));
                        end
                        if (uop.op == ALU_CTRL) begin
                            st_c_reg[axis_reg] <= sat_coord(res_d);
                        end
                        if (last_uop) begin
                            pc_reg   <= '0;
                            axis_reg <= 1'b1;
                        end else begin
                            pc_reg <= pc_reg + PCW'(1);
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_quad_start_x  <= st_s_reg[0];
                        m_quad_start_y  <= st_s_reg[1];
                        m_quad_ctrl_x   <= st_c_reg[0];
                        m_quad_ctrl_y   <= st_c_reg[1];
                        m_quad_end_x    <= st_e_reg[0];
                        m_quad_end_y    <= st_e_reg[1];
                        m_segment_index <= i_reg;
                        m_last_segment  <= last_seg;
                        m_count_capped  <= capped_reg;
                        i_reg           <= i_reg + IW'(1);
                        t0_reg          <= t1_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    cbq_ram #(
        .WIDTH (DW),
        .DEPTH (RAM_DEPTH)
    ) u_scratch (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 ({axis_reg, uop.src_a}),
        .rdata0 (rd0),
        .raddr1 ({axis_reg, uop.src_b}),
        .rdata1 (rd1)
    );

    cbq_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

endmodule
`default_nettype wire

>>> hw/rtl/cbq_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module cbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    output logic      [WIDTH-1:0]         rdata0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

>>> hw/rtl/cbq_alu.sv
// Shared serial arithmetic unit: shift-add multiply, restoring divide, lerp, control-point, add and subtract ops.
`default_nettype none
module cbq_alu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cbq_pkg::alu_req_t req,
    output cbq_pkg::alu_rsp_t      rsp
);
    import cbq_pkg::*;

    localparam logic signed [AW-1:0] HALF16 = AW'(1) <<< 15;
    localparam logic signed [AW-1:0] HALF26 = AW'(1) <<< 25;

    logic                 busy_reg;
    logic                 done_reg;
    alu_mode_t            mode_reg;
    logic signed [AW-1:0] x_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] res_reg;
    logic [TW-1:0]        y_reg;
    logic signed [XW-1:0] a_reg;
    logic [NW-1:0]        rem_reg;
    logic [CNTW-1:0]      cnt_reg;

    logic [NW:0]          div_sh;
    logic                 div_ge;
    logic [NW:0]          div_diff;
    logic signed [AW-1:0] a_ext;
    logic signed [AW-1:0] post;

    always_comb begin
        a_ext    = AW'(a_reg);
        div_sh   = {rem_reg, x_reg[DNW-1]};
        div_ge   = div_sh >= {1'b0, y_reg[NW-1:0]};
        div_diff = div_sh - {1'b0, y_reg[NW-1:0]};
        case (mode_reg)
            ALU_LERP: post = a_ext + ((acc_reg + HALF16) >>> 16);
            ALU_CTRL: post = ((a_ext <<< 17) + acc_reg + HALF26) >>> 26;
            ALU_DIV:  post = AW'(x_reg[DNW-1:0]);
            default:  post = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (req.start) begin
                done_reg <= 1'b0;
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                a_reg    <= req.a;
                rem_reg  <= '0;
                cnt_reg  <= CNTW'(DNW);
                case (req.mode)
                    ALU_LERP: begin
                        acc_reg <= '0;
                        x_reg   <= AW'(req.b) - AW'(req.a);
                        y_reg   <= req.t;
                    end
                    ALU_CTRL: begin
                        acc_reg <= '0;
                        x_reg   <= AW'(req.b);
                        y_reg   <= req.t;
                    end
                    ALU_SUB: begin
                        acc_reg <= AW'(req.a) - AW'(req.b);
                        y_reg   <= '0;
                    end
                    ALU_ADD: begin
                        acc_reg <= AW'(req.a) + AW'(req.b);
                        y_reg   <= '0;
                    end
                    default: begin
                        acc_reg <= '0;
                        x_reg   <= AW'(req.a);
                        y_reg   <= req.t;
                    end
                endcase
            end else if (busy_reg) begin
                if (mode_reg == ALU_DIV) begin
                    if (cnt_reg == '0) begin
                        res_reg  <= post;
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                    end else begin
                        done_reg       <= 1'b0;
                        x_reg[DNW-1:0] <= {x_reg[DNW-2:0], div_ge};
                        rem_reg        <= div_ge ? div_diff[NW-1:0] : div_sh[NW-1:0];
                        cnt_reg        <= cnt_reg - CNTW'(1);
                    end
                end else if (y_reg == '0) begin
                    res_reg  <= post;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    done_reg <= 1'b0;
                    acc_reg  <= acc_reg + (y_reg[0] ? x_reg : '0);
                    x_reg    <= x_reg <<< 1;
                    y_reg    <= y_reg >> 1;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule
`default_nettype wire

>>> tb/cubic_bezier_to_quads_top_test.sv
// Self-checking testbench for the cubic-to-quadratic Bezier splitter.
`timescale 1ns / 100ps
module cubic_bezier_to_quads_top_test;
    import cbq_pkg::*;

    localparam int  LIMIT_CYCLES = 80000000;
    localparam int  LONG_HOLD    = 3000;
    localparam int  CMAX         = 8388607;
    localparam int  CMIN         = -8388608;

    typedef struct packed {
        logic signed [23:0] sx, sy, cx, cy, ex, ey;
        logic [5:0]         idx;
        logic               last, capped;
    } quad_t;

    typedef struct {
        int    pt[8];
        bit    typed;
        int    want;
    } row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]          cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [23:0]        s_pt[8];
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [23:0]        m_sx, m_sy, m_cx, m_cy, m_ex, m_ey;
    logic [5:0]                m_idx;
    logic                      m_last, m_capped;

    quad_t   quad_q[$];
    longint  tol_model = 1106;
    int      err_cnt = 0;
    int      cycles = 0;
    bit      no_idle = 1'b0;
    int      hold_asked = 0;
    int      hold_done = 0;
    row_t    dir_tab[12];

    initial for (int k = 0; k < 8; k++) s_pt[k] = '0;

    cubic_bezier_to_quads_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_pt[0]), .s_start_y(s_pt[1]),
        .s_ctrl1_x(s_pt[2]), .s_ctrl1_y(s_pt[3]),
        .s_ctrl2_x(s_pt[4]), .s_ctrl2_y(s_pt[5]),
        .s_end_x(s_pt[6]), .s_end_y(s_pt[7]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quad_start_x(m_sx), .m_quad_start_y(m_sy),
        .m_quad_ctrl_x(m_cx), .m_quad_ctrl_y(m_cy),
        .m_quad_end_x(m_ex), .m_quad_end_y(m_ey),
        .m_segment_index(m_idx), .m_last_segment(m_last),
        .m_count_capped(m_capped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t timeout", $time);
            $display("cubic_bezier_to_quads_top_test: errors");
            $finish;
        end
    end

    // fixed-point predictor
    function automatic longint lerp(longint a, longint b, longint t);
        return a + (((b - a) * t + 32768) >>> 16);
    endfunction

    function automatic longint pt_at(longint p[4], longint t);
        longint a, b, c;
        a = lerp(p[0], p[1], t);
        b = lerp(p[1], p[2], t);
        c = lerp(p[2], p[3], t);
        return lerp(lerp(a, b, t), lerp(b, c, t), t);
    endfunction

    function automatic longint slope_at(longint p[4], longint t);
        return lerp(lerp(p[1] - p[0], p[2] - p[1], t), lerp(p[2] - p[1], p[3] - p[2], t), t);
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > CMAX) return 24'(CMAX);
        if (v < CMIN) return 24'(CMIN);
        return 24'(v);
    endfunction

    function automatic longint tparam(longint k, longint n);
        return (k * 65536 + n / 2) / n;
    endfunction

    task automatic predict_quads(input int pt[8]);
        longint px[4], py[4], dx, dy, err, e, p6, need, n;
        longint t0, t1, dt, sx, sy, ex, ey, gx, gy;
        bit     capped;
        quad_t  q;
        for (int k = 0; k < 4; k++) begin
            px[k] = pt[2*k];
            py[k] = pt[2*k+1];
        end
        dx = (3 * px[2] - px[3]) - (3 * px[1] - px[0]);
        dy = (3 * py[2] - py[3]) - (3 * py[1] - py[0]);
        err = dx * dx + dy * dy;
        e = (err + 255) >> 8;
        capped = 1'b1;
        n = MAX_QUADS;
        for (longint c = 1; c <= MAX_QUADS; c++) begin
            p6 = c * c * c;
            p6 = p6 * p6;
            need = e / p6 + ((e % p6) != 0);
            if (tol_model >= need) begin
                n = c;
                capped = 1'b0;
                break;
            end
        end
        for (int k = 0; k < 4; k++) begin
            px[k] = px[k] <<< 8;
            py[k] = py[k] <<< 8;
        end
        for (longint i = 0; i < n; i++) begin
            t0 = tparam(i, n);
            t1 = tparam(i + 1, n);
            dt = t1 - t0;
            sx = pt_at(px, t0);
            sy = pt_at(py, t0);
            ex = pt_at(px, t1);
            ey = pt_at(py, t1);
            gx = slope_at(px, t0) - slope_at(px, t1);
            gy = slope_at(py, t0) - slope_at(py, t1);
            q.sx = clamp24((sx + 128) >>> 8);
            q.sy = clamp24((sy + 128) >>> 8);
            q.cx = clamp24((2 * (sx + ex) * 65536 + 3 * gx * dt + (64'sd1 <<< 25)) >>> 26);
            q.cy = clamp24((2 * (sy + ey) * 65536 + 3 * gy * dt + (64'sd1 <<< 25)) >>> 26);
            q.ex = clamp24((ex + 128) >>> 8);
            q.ey = clamp24((ey + 128) >>> 8);
            q.idx = 6'(i);
            q.last = (i + 1 == n);
            q.capped = capped;
            quad_q.push_back(q);
        end
    endtask

    task automatic send_cubic(input int pt[8]);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        for (int k = 0; k < 8; k++) s_pt[k] <= 24'(pt[k]);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_quads(pt);
        @(negedge aclk);
    endtask

    task automatic send_typed(input row_t r);
        quad_t q;
        int    gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        for (int k = 0; k < 8; k++) s_pt[k] <= 24'(r.pt[k]);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        q = '{24'(r.want), 24'(r.want), 24'(r.want), 24'(r.want), 24'(r.want),
              24'(r.want), 6'd0, 1'b1, 1'b0};
        quad_q.push_back(q);
        @(negedge aclk);
    endtask

    task automatic drain_and_write(input logic [31:0] tol);
        s_valid <= 1'b0;
        while (quad_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= tol;
        tol_model = tol;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic int rand_coord();
        logic [23:0] v;
        v = 24'($urandom);
        return int'($signed(v));
    endfunction

    // curve around a random base point, control spread bounded by reach
    task automatic rand_curve(output int pt[8], input int reach);
        int bx, by;
        bx = int'($urandom_range(0, 16777215 - 2 * reach)) + CMIN + reach;
        by = int'($urandom_range(0, 16777215 - 2 * reach)) + CMIN + reach;
        for (int k = 0; k < 4; k++) begin
            pt[2*k]   = bx + int'($urandom_range(0, 2 * reach)) - reach;
            pt[2*k+1] = by + int'($urandom_range(0, 2 * reach)) - reach;
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // receiver: random stall per transaction, plus one long hold on request
    initial begin
        int gap;
        gap = 0;
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_done) begin
                m_ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(negedge aclk);
                hold_done = hold_asked;
            end
            if (gap > 0 && !no_idle) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
                if (m_valid) gap = $urandom_range(0, 5);
            end
        end
    end

    always @(posedge aclk) begin
        quad_t want;
        if (aresetn && m_valid && m_ready) begin
            if (quad_q.size() == 0) begin
                $display("%0t unexpected transaction: idx %0d", $time, m_idx);
                err_cnt++;
            end else begin
                want = quad_q.pop_front();
                check_field("start_x", want.sx, m_sx);
                check_field("start_y", want.sy, m_sy);
                check_field("ctrl_x", want.cx, m_cx);
                check_field("ctrl_y", want.cy, m_cy);
                check_field("end_x", want.ex, m_ex);
                check_field("end_y", want.ey, m_ey);
                check_field("segment_index", 24'(want.idx), 24'(m_idx));
                check_field("last_segment", 24'(want.last), 24'(m_last));
                check_field("count_capped", 24'(want.capped), 24'(m_capped));
            end
        end
    end

    initial begin
        int pt[8];
        int base, stp;
        int wait_cnt;
        dir_tab[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0};
        dir_tab[1]  = '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, CMAX};
        dir_tab[2]  = '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, CMIN};
        dir_tab[3]  = '{'{CMIN, 0, CMIN + 5592405, 1, CMIN + 11184810, 2, CMAX, 3}, 1'b0, 0};
        dir_tab[4]  = '{'{CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX}, 1'b0, 0};
        dir_tab[5]  = '{'{0, 0, 256, 512, 512, 512, 768, 0}, 1'b0, 0};
        dir_tab[6]  = '{'{-1000, 0, 0, 3000, 1000, -3000, 2000, 0}, 1'b0, 0};
        dir_tab[7]  = '{'{100, 100, 5000, -5000, -5000, -5000, 100, 100}, 1'b0, 0};
        dir_tab[8]  = '{'{0, 0, 0, 0, 4096, 4096, 4096, 4096}, 1'b0, 0};
        dir_tab[9]  = '{'{8388600, -8388600, CMAX, CMIN, CMAX, CMIN, 8388600, -8388600},
                        1'b0, 0};
        dir_tab[10] = '{'{-1, -1, -2, 3, 4, -5, -6, 7}, 1'b0, 0};
        dir_tab[11] = '{'{1, -1, 255, -255, -257, 257, 129, -127}, 1'b0, 0};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default tolerance after reset
        foreach (dir_tab[r]) begin
            if (dir_tab[r].typed) send_typed(dir_tab[r]);
            else send_cubic(dir_tab[r].pt);
        end

        // zero tolerance: only straight uniform cubics stay at one segment
        drain_and_write(32'd0);
        for (int j = 0; j < 6; j++) begin
            base = rand_coord() / 2;
            stp = int'($urandom_range(0, 2000000)) - 1000000;
            for (int k = 0; k < 4; k++) begin
                pt[2*k] = base + k * stp;
                pt[2*k+1] = -base + k * (stp / 3);
            end
            send_cubic(pt);
        end
        rand_curve(pt, 300);
        send_cubic(pt);

        drain_and_write(32'hFFFF_FFFF);
        for (int j = 0; j < 150; j++) begin
            if (j == 40) hold_asked++;
            if ($urandom_range(0, 9) < 3) begin
                for (int k = 0; k < 8; k++) pt[k] = rand_coord();
            end else begin
                rand_curve(pt, 4096);
            end
            send_cubic(pt);
        end

        // back-to-back stretch with tight tolerance
        drain_and_write(32'd1);
        no_idle = 1'b1;
        for (int j = 0; j < 20; j++) begin
            rand_curve(pt, 4);
            send_cubic(pt);
        end
        no_idle = 1'b0;

        for (int ph = 0; ph < 3; ph++) begin
            drain_and_write(32'($urandom_range(1000, 1 << 20)));
            for (int j = 0; j < 55; j++) begin
                rand_curve(pt, 256);
                send_cubic(pt);
            end
        end

        s_valid <= 1'b0;
        while (quad_q.size() != 0) @(negedge aclk);
        wait_cnt = 0;
        while (wait_cnt < 2000) begin
            @(negedge aclk);
            wait_cnt++;
        end
        if (err_cnt == 0) begin
            $display("cubic_bezier_to_quads_top_test: clean");
        end else begin
            $display("cubic_bezier_to_quads_top_test: errors");
        end
        $finish;
    end
endmodule
